// ----- hw/rtl/actr_pkg.sv -----
// Shared types, constants and the AES S-box for the counter-mode byte cipher.
`default_nettype none

package actr_pkg;

    localparam int unsigned BlockBytes = 16;
    localparam int unsigned RkRows     = 15;

    localparam logic [2:0] REG_KEY0  = 3'd0;
    localparam logic [2:0] REG_KEY1  = 3'd1;
    localparam logic [2:0] REG_KEY2  = 3'd2;
    localparam logic [2:0] REG_KEY3  = 3'd3;
    localparam logic [2:0] REG_MODE  = 3'd4;
    localparam logic [2:0] REG_NONCE = 3'd5;

    localparam logic [1:0] MODE_AES128 = 2'd0;
    localparam logic [1:0] MODE_AES192 = 2'd1;
    localparam logic [1:0] MODE_AES256 = 2'd2;

    typedef struct packed {
        logic [7:0] data_in;
        logic       in_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] data_out;
        logic       out_last;
    } out_item_t;

    // One round-key word write from the expander into the round-key memory.
    typedef struct packed {
        logic        we;
        logic [3:0]  row;
        logic [1:0]  col;
        logic [31:0] word;
    } rk_wr_t;

    typedef struct packed {
        logic         valid;
        logic [127:0] block;
    } ks_done_t;

    localparam logic [7:0] SBOX [256] = '{
        8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
        8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
        8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
        8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
        8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
        8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
        8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
        8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
        8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
        8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
        8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
        8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
        8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
        8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
        8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
        8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };

    function automatic logic [7:0] gf_double(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/actr_kexp.sv -----
// AES key expander that writes one round-key word per cycle.
`default_nettype none

module actr_kexp (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [3:0][63:0] key_words,
    input  wire logic [1:0]       mode,
    output actr_pkg::rk_wr_t      rk_wr,
    output logic                  done
);

    logic        busy_reg;
    logic [5:0]  idx_reg;
    logic [2:0]  phase_reg;
    logic [7:0]  rcon_reg;
    logic [31:0] hist_reg [8];

    logic [3:0]  nk;
    logic [5:0]  last_idx;
    logic [2:0]  nk_m1;
    logic [31:0] w1;
    logic [31:0] wnk;
    logic [31:0] rot;
    logic [31:0] sub_in;
    logic [31:0] sub_out;
    logic [31:0] word;
    logic [63:0] kw;
    logic        from_key;

    always_comb
    begin
        case (mode)
            actr_pkg::MODE_AES128:
            begin
                nk = 4'd4;
                last_idx = 6'd43;
            end
            actr_pkg::MODE_AES192:
            begin
                nk = 4'd6;
                last_idx = 6'd51;
            end
            default:
            begin
                nk = 4'd8;
                last_idx = 6'd59;
            end
        endcase
        nk_m1 = 3'(nk - 4'd1);
        w1 = hist_reg[0];
        wnk = hist_reg[nk_m1];
        rot = {w1[23:0], w1[31:24]};
        sub_in = (phase_reg == 3'd0) ? rot : w1;
        for (int k = 0; k < 4; k++)
        begin
            sub_out[k*8 +: 8] = actr_pkg::SBOX[sub_in[k*8 +: 8]];
        end
        from_key = ({2'b00, idx_reg} < {4'd0, nk});
        kw = key_words[~idx_reg[2:1]];
        if (from_key)
        begin
            word = idx_reg[0] ? kw[31:0] : kw[63:32];
        end
        else if (phase_reg == 3'd0)
        begin
            word = wnk ^ sub_out ^ {rcon_reg, 24'd0};
        end
        else if (nk == 4'd8 && phase_reg == 3'd4)
        begin
            word = wnk ^ sub_out;
        end
        else
        begin
            word = wnk ^ w1;
        end
    end

    assign rk_wr.we   = busy_reg;
    assign rk_wr.row  = idx_reg[5:2];
    assign rk_wr.col  = idx_reg[1:0];
    assign rk_wr.word = word;
    assign done       = !busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b1;
            idx_reg   <= '0;
            phase_reg <= '0;
            rcon_reg  <= 8'h01;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            idx_reg   <= '0;
            phase_reg <= '0;
            rcon_reg  <= 8'h01;
        end
        else if (busy_reg)
        begin
            idx_reg   <= idx_reg + 6'd1;
            phase_reg <= (phase_reg == nk_m1) ? 3'd0 : phase_reg + 3'd1;
            if (!from_key && phase_reg == 3'd0)
            begin
                rcon_reg <= actr_pkg::gf_double(rcon_reg);
            end
            if (idx_reg == last_idx)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            hist_reg[0] <= word;
            for (int k = 1; k < 8; k++)
            begin
                hist_reg[k] <= hist_reg[k-1];
            end
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/actr_core.sv -----
// Iterative AES encryption engine with its round-key memory, one round per cycle.
`default_nettype none

module actr_core (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         flush,
    input  wire logic         start,
    input  wire logic [127:0] ctr_block,
    input  wire logic [1:0]   mode,
    input  wire actr_pkg::rk_wr_t rk_wr,
    output logic              idle,
    output actr_pkg::ks_done_t done
);

    logic [127:0] rk_mem [actr_pkg::RkRows];
    logic [127:0] rk_q;
    logic [3:0]   rd_addr;

    logic         busy_reg;
    logic [3:0]   rnd_reg;
    logic [127:0] state_reg;
    logic         done_reg;

    logic [3:0]   nr;
    logic [127:0] sb;
    logic [127:0] sr;
    logic [127:0] mc;
    logic [127:0] round_out;
    logic [7:0]   a0, a1, a2, a3, all;

    always_comb
    begin
        case (mode)
            actr_pkg::MODE_AES128: nr = 4'd10;
            actr_pkg::MODE_AES192: nr = 4'd12;
            default:               nr = 4'd14;
        endcase
        for (int k = 0; k < 16; k++)
        begin
            sb[127 - 8*k -: 8] = actr_pkg::SBOX[state_reg[127 - 8*k -: 8]];
        end
        for (int c = 0; c < 4; c++)
        begin
            for (int r = 0; r < 4; r++)
            begin
                sr[127 - 8*(c*4 + r) -: 8] = sb[127 - 8*((((c + r) % 4) * 4) + r) -: 8];
            end
        end
        for (int c = 0; c < 4; c++)
        begin
            a0 = sr[127 - 8*(c*4) -: 8];
            a1 = sr[127 - 8*(c*4 + 1) -: 8];
            a2 = sr[127 - 8*(c*4 + 2) -: 8];
            a3 = sr[127 - 8*(c*4 + 3) -: 8];
            all = a0 ^ a1 ^ a2 ^ a3;
            mc[127 - 8*(c*4) -: 8]     = a0 ^ all ^ actr_pkg::gf_double(a0 ^ a1);
            mc[127 - 8*(c*4 + 1) -: 8] = a1 ^ all ^ actr_pkg::gf_double(a1 ^ a2);
            mc[127 - 8*(c*4 + 2) -: 8] = a2 ^ all ^ actr_pkg::gf_double(a2 ^ a3);
            mc[127 - 8*(c*4 + 3) -: 8] = a3 ^ all ^ actr_pkg::gf_double(a3 ^ a0);
        end
        if (rnd_reg == 4'd0)
        begin
            round_out = state_reg ^ rk_q;
        end
        else if (rnd_reg == nr)
        begin
            round_out = sr ^ rk_q;
        end
        else
        begin
            round_out = mc ^ rk_q;
        end
        // The row for the next round is registered into rk_q in the cycle before that round.
        if (!busy_reg || rnd_reg >= nr)
        begin
            rd_addr = 4'd0;
        end
        else
        begin
            rd_addr = rnd_reg + 4'd1;
        end
    end

    assign idle       = !busy_reg;
    assign done.valid = done_reg;
    assign done.block = state_reg;

    always_ff @(posedge clk)
    begin
        if (rk_wr.we)
        begin
            rk_mem[rk_wr.row][{~rk_wr.col, 5'd0} +: 32] <= rk_wr.word;
        end
        rk_q <= rk_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            rnd_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (flush)
        begin
            busy_reg <= 1'b0;
            rnd_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                rnd_reg  <= '0;
            end
            else if (busy_reg)
            begin
                rnd_reg <= rnd_reg + 4'd1;
                if (rnd_reg == nr)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy_reg)
        begin
            state_reg <= ctr_block;
        end
        else if (busy_reg)
        begin
            state_reg <= round_out;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/aes_ctr_byte_stream_cipher_unit.sv -----
// Top level of the AES counter-mode byte stream cipher.
`default_nettype none

// Each accepted item is one byte; it leaves XORed with the next keystream byte,
// in order, one result per item, and the block sustains one item per clock
// while keystream is on hand and the output is not stalled. Keystream blocks
// are AES(key, nonce || byte_count/16) and are made by an iterative engine
// that does one round per cycle, reading one row of the round-key memory per
// round. Two keystream blocks are buffered: while one is being consumed, the
// next is produced, which is what holds that item rate. After reset and after
// any write of a key word or the mode, the key expander fills the round-key
// memory one word per cycle (44, 52 or 60 words); then the first block is
// made, and in_ready stays low until it is ready. A nonce write only restarts
// block production. Any key, mode or nonce write clears the byte count, so
// the next item starts a new stream with counter zero. Writes must only be
// made while the block holds no undelivered item.
module aes_ctr_byte_stream_cipher_unit (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire actr_pkg::in_item_t in_data,
    output logic               out_valid,
    input  wire logic          out_ready,
    output actr_pkg::out_item_t out_data,
    input  wire logic          cfg_we,
    input  wire logic [2:0]    cfg_index,
    input  wire logic [63:0]   cfg_wdata
);

    logic [3:0][63:0] key_reg;
    logic [1:0]       mode_reg;
    logic [63:0]      nonce_reg;

    logic [63:0]  byte_count_reg;
    logic [59:0]  gen_ctr_reg;
    logic [127:0] ks_buf_reg [2];
    logic [1:0]   ks_valid_reg;

    logic                out_valid_reg;
    actr_pkg::out_item_t out_reg;

    logic                key_write;
    logic                flush;
    logic                exp_done;
    logic                core_idle;
    logic                core_start;
    actr_pkg::rk_wr_t    rk_wr;
    actr_pkg::ks_done_t  ks_done;

    logic         in_fire;
    logic         slot;
    logic [3:0]   pos;
    logic [127:0] cur_blk;
    logic [7:0]   ks_byte;
    logic [59:0]  gen_sel;
    logic         gen_free;

    // Key-word and mode writes re-run the key schedule; every stream
    // register write restarts the counter.
    assign key_write = cfg_we && (cfg_index == actr_pkg::REG_KEY0 ||
                                  cfg_index == actr_pkg::REG_KEY1 ||
                                  cfg_index == actr_pkg::REG_KEY2 ||
                                  cfg_index == actr_pkg::REG_KEY3 ||
                                  cfg_index == actr_pkg::REG_MODE);
    assign flush = key_write || (cfg_we && cfg_index == actr_pkg::REG_NONCE);

    assign slot    = byte_count_reg[4];
    assign pos     = byte_count_reg[3:0];
    assign cur_blk = ks_buf_reg[slot];
    assign ks_byte = cur_blk[{~pos, 3'd0} +: 8];

    assign in_ready = ks_valid_reg[slot] && (!out_valid_reg || out_ready);
    assign in_fire  = in_valid && in_ready;

    // The next block to start is the one after the block being delivered in
    // this cycle, so the engine can restart in its done cycle. A slot whose
    // last byte leaves in this cycle already counts as free.
    assign gen_sel  = gen_ctr_reg + {59'd0, ks_done.valid};
    assign gen_free = !ks_valid_reg[gen_sel[0]] ||
                      (in_fire && pos == 4'hf && slot == gen_sel[0]);

    // The engine starts only with a complete key schedule and a free slot.
    assign core_start = core_idle && exp_done && gen_free && !flush;

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    actr_kexp u_kexp (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (key_write),
        .key_words (key_reg),
        .mode      (mode_reg),
        .rk_wr     (rk_wr),
        .done      (exp_done)
    );

    actr_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .flush     (flush),
        .start     (core_start),
        .ctr_block ({nonce_reg, 4'd0, gen_sel}),
        .mode      (mode_reg),
        .rk_wr     (rk_wr),
        .idle      (core_idle),
        .done      (ks_done)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg  <= '0;
            mode_reg <= actr_pkg::MODE_AES256;
            nonce_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                actr_pkg::REG_KEY0:  key_reg[3] <= cfg_wdata;
                actr_pkg::REG_KEY1:  key_reg[2] <= cfg_wdata;
                actr_pkg::REG_KEY2:  key_reg[1] <= cfg_wdata;
                actr_pkg::REG_KEY3:  key_reg[0] <= cfg_wdata;
                actr_pkg::REG_MODE:  mode_reg   <= cfg_wdata[1:0];
                actr_pkg::REG_NONCE: nonce_reg  <= cfg_wdata;
                default:             ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            gen_ctr_reg    <= '0;
            ks_valid_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else if (flush)
        begin
            byte_count_reg <= '0;
            gen_ctr_reg    <= '0;
            ks_valid_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                byte_count_reg <= byte_count_reg + 64'd1;
                out_valid_reg  <= 1'b1;
                if (pos == 4'hf)
                begin
                    ks_valid_reg[slot] <= 1'b0;
                end
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            // The producer only fills the slot the consumer is not using.
            if (ks_done.valid)
            begin
                ks_valid_reg[gen_ctr_reg[0]] <= 1'b1;
                gen_ctr_reg <= gen_ctr_reg + 60'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            out_reg.data_out <= in_data.data_in ^ ks_byte;
            out_reg.out_last <= in_data.in_last;
        end
        if (ks_done.valid)
        begin
            ks_buf_reg[gen_ctr_reg[0]] <= ks_done.block;
        end
    end

`ifndef SYNTHESIS
    a_done_into_free_slot : assert property (@(posedge clk) disable iff (!rst_n)
        ks_done.valid |-> !ks_valid_reg[gen_ctr_reg[0]])
        else $error("keystream block written into a slot still in use");

    a_start_after_schedule : assert property (@(posedge clk) disable iff (!rst_n)
        core_start |-> exp_done)
        else $error("engine started while the key schedule was incomplete");

    a_slot_released : assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && pos == 4'hf) |=> !ks_valid_reg[$past(slot)])
        else $error("consumed keystream slot was not released");

    a_out_follows_accept : assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && !flush) |=> out_valid_reg)
        else $error("accepted item produced no result");
`endif

endmodule

`default_nettype wire
